// ----- design/trie_signature_prefix_match_unit_macros.svh -----
// assertion macros for the trie signature prefix match unit
// used by the top level only, no other dependencies
`ifndef TRIE_SIGNATURE_PREFIX_MATCH_UNIT_MACROS_SVH
`define TRIE_SIGNATURE_PREFIX_MATCH_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TSPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define TSPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tspm_pkg.sv -----
// shared constants, status codes and controller/datapath command types
// for the trie signature prefix match unit; no dependencies
package tspm_pkg;

	localparam int NODE_COUNT = 256;
	localparam int CODE_BITS  = 16;
	localparam int FANOUT     = 256;

	localparam int NODE_BITS = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int NF_BITS   = $clog2(NODE_COUNT + 1);
	localparam int CT_DEPTH  = NODE_COUNT * FANOUT;
	localparam int CT_AW     = NODE_BITS + 8;

	localparam logic [1:0] STATUS_NO_MATCH = 2'd0;
	localparam logic [1:0] STATUS_MATCH    = 2'd1;
	localparam logic [1:0] STATUS_INSERTED = 2'd2;
	localparam logic [1:0] STATUS_FULL     = 2'd3;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	typedef struct packed {
		logic clear;
		logic accept;
		logic look;
		logic hit;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_end;
		logic walk_done;
		logic hit;
		logic last;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- design/trie_signature_prefix_match_unit.sv -----
// top level of the trie signature prefix match unit
// depends on tspm_pkg, tspm_ctrl, tspm_datapath and the assertion macro header
//
// usage
// - input channel (in_valid / in_stall) takes one byte word of a signature or log line:
//   mode (0 insert, 1 search), byte_value, last_byte, threat_code (insert only)
// - output channel (out_valid / out_stall) gives one result word per last byte:
//   status (0 no match, 1 match, 2 inserted, 3 table full) and found_code
// - every byte while the walk runs costs one dependent read of the child link memory from
//   the current node: accept, then look-up and walk update; a search that meets an end
//   mark adds a code store read; a byte after the walk has stopped is only accepted
// - a last byte leads to the result state, which loads the result register once that
//   register is free (directly after the accept when the walk had already stopped)
// - at reset the node table (NODE_COUNT * 256 links, 65536 with 256 nodes) is swept to
//   zero, one link a cycle; in_stall stays high for the whole sweep
// - end marks sit in flip-flops and clear at once; the node counter restarts at one
// - a stalled result holds in the output register; the next byte words are still taken
//   until another result is ready, which then waits for the register to drain
`include "trie_signature_prefix_match_unit_macros.svh"

module trie_signature_prefix_match_unit
	import tspm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	input  logic [15:0] threat_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] found_code
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing of clear sweep, look-up, code fetch and result load
	tspm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_byte (last_byte),
		.stat      (stat),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	// node memory, walk registers and the result register
	tspm_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.byte_value  (byte_value),
		.last_byte   (last_byte),
		.threat_code (threat_code),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found_code  (found_code)
	);

	// only a match carries a code
	`TSPM_ASSERT_IMPLY(a_code_only_on_match, clk, arst_n,
		out_valid && (status != STATUS_MATCH), found_code == 16'd0, "code without match")

	// a last byte always needs the result cycle, so the input is busy next
	`TSPM_ASSERT_NEXT(a_last_blocks_input, clk, arst_n,
		in_valid && !in_stall && last_byte, in_stall, "input taken during result")

	// a result is only loaded by the controller, never straight from an accepted word
	`TSPM_ASSERT_IMPLY(a_result_from_fin, clk, arst_n,
		cmd.finish, !cmd.accept && !cmd.look && !cmd.clear, "result load overlaps walk")

endmodule

// ----- design/tspm_ctrl.sv -----
// controller state machine for the trie walk
// depends on tspm_pkg for the command and status structs
module tspm_ctrl
	import tspm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     last_byte,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     in_stall
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_LOOK  = 3'd2;
	localparam logic [2:0] ST_HIT   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.walk_done) begin
						state_d = last_byte ? ST_FIN : ST_IDLE;
					end else begin
						state_d = ST_LOOK;
					end
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				if (stat.hit) begin
					state_d = ST_HIT;
				end else begin
					state_d = stat.last ? ST_FIN : ST_IDLE;
				end
			end
			ST_HIT: begin
				cmd.hit = 1'b1;
				state_d = stat.last ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ----- design/tspm_datapath.sv -----
// datapath: child link memory, end marks, code store, walk state and result register
// depends on tspm_pkg; driven by tspm_ctrl commands
module tspm_datapath
	import tspm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic                  mode,
	input  logic [7:0]            byte_value,
	input  logic                  last_byte,
	input  logic [15:0]           threat_code,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [15:0]           found_code
);

	// child link memory and its registered read
	logic [NODE_BITS-1:0] ct_mem [0:CT_DEPTH-1];
	logic [NODE_BITS-1:0] child_q;
	logic [CT_AW-1:0]     ct_addr;
	logic                 ct_we;
	logic [NODE_BITS-1:0] ct_wdata;
	logic [CT_AW-1:0]     clr_q;

	// code store, undefined until written
	logic [CODE_BITS-1:0] code_mem [0:NODE_COUNT-1];
	logic [CODE_BITS-1:0] code_rd_q;

	logic [NODE_COUNT-1:0] end_mark_q;

	// latched word
	logic                 mode_q;
	logic [7:0]           byte_q;
	logic                 last_q;
	logic [CODE_BITS-1:0] code_q;

	// walk state
	logic [NODE_BITS-1:0] cursor_q;
	logic [NF_BITS-1:0]   next_free_q;
	logic                 walk_done_q;
	logic [1:0]           walk_status_q;
	logic [CODE_BITS-1:0] walk_code_q;

	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [15:0]          found_code_q;

	logic child_zero;
	logic table_full;
	logic alloc;
	logic hit;
	logic mark_now;

	assign child_zero = (child_q == '0);
	assign table_full = (next_free_q >= NF_BITS'(NODE_COUNT));
	assign alloc      = cmd.look && (mode_q == MODE_INSERT) && child_zero && !table_full;
	assign hit        = (mode_q == MODE_SEARCH) && !child_zero && end_mark_q[child_q];
	assign mark_now   = cmd.finish && !walk_done_q && (mode_q == MODE_INSERT);

	always_comb begin
		ct_we    = 1'b0;
		ct_wdata = next_free_q[NODE_BITS-1:0];
		priority if (cmd.clear) begin
			ct_addr  = clr_q;
			ct_we    = 1'b1;
			ct_wdata = '0;
		end else if (cmd.look) begin
			ct_addr = {cursor_q, byte_q};
			ct_we   = alloc;
		end else begin
			ct_addr = {cursor_q, byte_value};
		end
	end

	always_ff @(posedge clk) begin
		if (ct_we) begin
			ct_mem[ct_addr] <= ct_wdata;
		end
		child_q <= ct_mem[ct_addr];
	end

	always_ff @(posedge clk) begin
		if (mark_now) begin
			code_mem[cursor_q] <= code_q;
		end
		code_rd_q <= code_mem[child_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear && !stat.clear_end) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q <= mode;
			byte_q <= byte_value;
			last_q <= last_byte;
			code_q <= threat_code[CODE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_mark_q    <= '0;
			cursor_q      <= '0;
			next_free_q   <= NF_BITS'(1);
			walk_done_q   <= 1'b0;
			walk_status_q <= STATUS_NO_MATCH;
			walk_code_q   <= '0;
		end else begin
			if (cmd.look) begin
				if (mode_q == MODE_INSERT) begin
					if (!child_zero) begin
						cursor_q <= child_q;
					end else if (table_full) begin
						walk_done_q   <= 1'b1;
						walk_status_q <= STATUS_FULL;
						walk_code_q   <= '0;
					end else begin
						cursor_q    <= next_free_q[NODE_BITS-1:0];
						next_free_q <= next_free_q + 1'b1;
					end
				end else begin
					if (child_zero) begin
						walk_done_q   <= 1'b1;
						walk_status_q <= STATUS_NO_MATCH;
						walk_code_q   <= '0;
					end else begin
						cursor_q <= child_q;
						if (end_mark_q[child_q]) begin
							walk_done_q   <= 1'b1;
							walk_status_q <= STATUS_MATCH;
						end
					end
				end
			end
			if (cmd.hit) begin
				walk_code_q <= code_rd_q;
			end
			if (cmd.finish) begin
				if (mark_now) begin
					end_mark_q[cursor_q] <= 1'b1;
				end
				cursor_q      <= '0;
				walk_done_q   <= 1'b0;
				walk_status_q <= STATUS_NO_MATCH;
				walk_code_q   <= '0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (walk_done_q) begin
				status_q     <= walk_status_q;
				found_code_q <= (walk_status_q == STATUS_MATCH) ? 16'(walk_code_q) : '0;
			end else begin
				status_q     <= (mode_q == MODE_INSERT) ? STATUS_INSERTED : STATUS_NO_MATCH;
				found_code_q <= '0;
			end
		end
	end

	assign stat.clear_end = (clr_q == CT_AW'(CT_DEPTH - 1));
	assign stat.walk_done = walk_done_q;
	assign stat.hit       = hit;
	assign stat.last      = last_q;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign found_code = found_code_q;

endmodule
